FILE: src/assert_macros.svh
// Assertion macros used by the UTF-8 stream decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, cond, conseq, msg) \
   `ASSERT_CLK(label, (cond) |=> (conseq), msg)

`endif

FILE: src/utf8sd_pkg.sv
// Package with the widths, constants and types of the UTF-8 stream decoder.
`timescale 1ns / 1ps
package utf8sd_pkg;

   localparam int BYTE_W    = 8;
   localparam int CP_W      = 21;
   localparam int DUE_W     = 2;
   localparam int CONT_BITS = 6;

   localparam logic [CP_W-1:0] CR_POINT = CP_W'(8'h0D);

   // One input word held in the input register.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] byte_in;
      logic              is_last_byte;
   } stage_type;

endpackage

FILE: src/utf8sd_req_if.sv
// Interface of the byte input channel.
`timescale 1ns / 1ps
interface utf8sd_req_if;
   logic                             valid;
   logic                             ready;
   logic [utf8sd_pkg::BYTE_W-1:0]    byte_in;
   logic                             is_last_byte;

   modport source (output valid, output byte_in, output is_last_byte, input ready);
   modport sink   (input valid, input byte_in, input is_last_byte, output ready);
endinterface

FILE: src/utf8sd_rsp_if.sv
// Interface of the code point result channel.
`timescale 1ns / 1ps
interface utf8sd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [utf8sd_pkg::CP_W-1:0]    code_point;
   logic                           has_char;
   logic                           end_of_text;

   modport source (output valid, output code_point, output has_char, output end_of_text,
                   input ready);
   modport sink   (input valid, input code_point, input has_char, input end_of_text,
                   output ready);
endinterface

FILE: src/utf8sd_in_stage.sv
// Input register stage of the UTF-8 stream decoder.
`timescale 1ns / 1ps
module utf8sd_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   utf8sd_req_if.sink            req_bus,
   input  logic                  take,
   output utf8sd_pkg::stage_type stage
);
   import utf8sd_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              last_ff;
   logic              accept;

   // The register may refill in the same cycle as the decoder takes its word.
   assign req_bus.ready = !valid_ff || take;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_bus.byte_in;
         last_ff <= req_bus.is_last_byte;
      end
   end

   assign stage.valid        = valid_ff;
   assign stage.byte_in      = byte_ff;
   assign stage.is_last_byte = last_ff;

endmodule

FILE: src/utf8sd_decode.sv
// Decoder state, classification logic and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module utf8sd_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  utf8sd_pkg::stage_type stage,
   output logic                  take,
   utf8sd_rsp_if.source          rsp_bus
);
   import utf8sd_pkg::*;

   logic [CP_W-1:0]   partial_ff, partial_in;
   logic [DUE_W-1:0]  due_ff, due_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]   cp_ff;
   logic              has_char_ff;
   logic              eot_ff;

   logic              cont;
   logic              done;
   logic              emit;
   logic [CP_W-1:0]   point_next;
   logic [DUE_W-1:0]  due_next;

   // A word moves on whenever the result register is free or being emptied.
   assign take = stage.valid && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      cont       = (due_ff != '0) && (stage.byte_in[BYTE_W-1 -: 2] == 2'b10);
      point_next = '0;
      due_next   = '0;
      done       = 1'b0;
      if (cont) begin
         point_next = {partial_ff[CP_W-CONT_BITS-1:0], stage.byte_in[CONT_BITS-1:0]};
         due_next   = due_ff - DUE_W'(1);
         done       = (due_next == '0);
      end else begin
         case (stage.byte_in) inside
            8'b0???????: begin
               point_next = CP_W'(stage.byte_in);
               done       = 1'b1;
            end
            8'b110?????: begin
               point_next = CP_W'(stage.byte_in[4:0]);
               due_next   = DUE_W'(1);
            end
            8'b1110????: begin
               point_next = CP_W'(stage.byte_in[3:0]);
               due_next   = DUE_W'(2);
            end
            8'b11110???: begin
               point_next = CP_W'(stage.byte_in[2:0]);
               due_next   = DUE_W'(3);
            end
            default: begin
               point_next = '0;
               due_next   = '0;
            end
         endcase
      end
      // Carriage returns are swallowed.
      if (done && (point_next == CR_POINT)) begin
         done = 1'b0;
      end
      emit = done || stage.is_last_byte;
   end

   always_comb begin
      if (stage.is_last_byte) begin
         partial_in = '0;
         due_in     = '0;
      end else begin
         partial_in = point_next;
         due_in     = due_next;
      end
      if (take) begin
         rsp_valid_in = emit;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         due_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            partial_ff <= partial_in;
            due_ff     <= due_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         cp_ff       <= done ? point_next : '0;
         has_char_ff <= done;
         eot_ff      <= stage.is_last_byte;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.code_point  = cp_ff;
   assign rsp_bus.has_char    = has_char_ff;
   assign rsp_bus.end_of_text = eot_ff;

   `ASSERT_CLK(a_empty_only_at_end, rsp_valid_ff && !has_char_ff |-> eot_ff, "empty result without end of text")
   `ASSERT_CLK(a_no_cr_out, rsp_valid_ff && has_char_ff |-> cp_ff != CR_POINT, "carriage return emitted")
   `ASSERT_NEXT(a_clean_after_end, take && stage.is_last_byte, due_ff == '0 && partial_ff == '0, "state not cleared after last byte")
   `ASSERT_NEXT(a_result_follows_take, take && emit, rsp_valid_ff, "result lost")

endmodule

FILE: src/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder.
// An accepted byte is held in the input register and decoded from there into the result
// register, which shows its word on the result channel.
// Throughput: one byte per cycle while the result channel does not stall, set by the combinational decode.
// A word waiting at the output lets one more byte into the input register; later bytes wait.
// Reset is synchronous and active high; it empties both registers and clears the decoder state.
`timescale 1ns / 1ps
module utf8_stream_decoder_unit (
   input  logic          clock,
   input  logic          reset,
   utf8sd_req_if.sink    req_bus,
   utf8sd_rsp_if.source  rsp_bus
);
   import utf8sd_pkg::*;

   // Word held in the input register, and the decoder's signal that it takes it.
   stage_type stage;
   logic      take;

   // The input register captures each incoming byte and its last-byte mark. It refills
   // in the same cycle as the decoder consumes the word it holds, so a steady stream
   // passes at one byte per cycle while the result channel does not stall.
   utf8sd_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .take    (take),
      .stage   (stage)
   );

   // The decoder keeps the partial code point and the count of continuation bytes still
   // due. It classifies the held byte, updates that state and loads the result register
   // when a character completes or when the byte ends the text. A broken sequence is
   // dropped and the offending byte starts afresh as a lead byte; the state returns to
   // its reset values after the last byte, so a new text starts clean.
   utf8sd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .take    (take),
      .rsp_bus (rsp_bus)
   );

endmodule
